>>> rtl/core/bsrch_pkg.sv
// Shared types and constants for the sorted-table binary search block.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package bsrch_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;  // key table entries
  localparam int unsigned KEY_W    = 32;  // key width
  localparam int unsigned IDX_W    = $clog2(TABLE_DEPTH);  // write index width
  localparam int unsigned POS_W    = IDX_W + 1;  // position / count width
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USED_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 8'd1;

  // input item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] write_index;
    logic [KEY_W-1:0] entry_value;
    logic [KEY_W-1:0] search_key;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_word_t;

  // result of one halving step
  typedef struct packed {
    logic             hit;
    logic             done;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] next_lo;
    logic [POS_W-1:0] next_n;
    logic [POS_W-1:0] next_probe;
  } step_t;

endpackage

>>> rtl/core/bsrch_table.sv
// Key table storage: single write port, single registered read port.
// Depends on bsrch_pkg for the key width.
`timescale 1ns / 1ps

module bsrch_table #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [bsrch_pkg::KEY_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [bsrch_pkg::KEY_W-1:0] rdata_o
);

  logic [bsrch_pkg::KEY_W-1:0] mem_q [DEPTH];
  logic [bsrch_pkg::KEY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bsrch_step.sv
// One halving step: compare the probed entry with the key and narrow the range.
// Depends on bsrch_pkg for step_t and widths.
`timescale 1ns / 1ps

module bsrch_step (
  input  logic [bsrch_pkg::POS_W-1:0] lo_i,
  input  logic [bsrch_pkg::POS_W-1:0] n_i,
  input  logic [bsrch_pkg::KEY_W-1:0] key_i,
  input  logic [bsrch_pkg::KEY_W-1:0] entry_i,
  input  logic                        desc_i,
  output bsrch_pkg::step_t            step_o
);

  logic [bsrch_pkg::POS_W-1:0] half;
  logic [bsrch_pkg::POS_W-1:0] probe;
  logic                        eq;
  logic                        go_right;
  logic [bsrch_pkg::POS_W-1:0] lo_n;
  logic [bsrch_pkg::POS_W-1:0] n_n;

  always_comb begin
    half     = n_i >> 1;
    probe    = lo_i + half;
    eq       = (key_i == entry_i);
    go_right = desc_i ? (key_i < entry_i) : (key_i > entry_i);
    if (go_right) begin
      lo_n = probe + 1'b1;
      n_n  = n_i - half - 1'b1;
    end else begin
      lo_n = lo_i;
      n_n  = half;
    end
    step_o.hit        = eq;
    step_o.done       = eq || (n_n == '0);
    step_o.pos        = eq ? probe : lo_n;
    step_o.next_lo    = lo_n;
    step_o.next_n     = n_n;
    step_o.next_probe = lo_n + (n_n >> 1);
  end

endmodule

>>> rtl/core/sorted_table_binary_search.sv
// Sorted key table with a halving binary search that returns a found flag and
// a position (match index or insertion point). Depends on bsrch_pkg,
// bsrch_table and bsrch_step.
`timescale 1ns / 1ps

// A write word is accepted while idle and produces no result. A search word
// first issues the table read of the middle entry, then runs one halving step
// per table read (one table read and one key compare through the shared step
// unit), at most floor(log2(n)) + 1 steps for n active entries, and then loads
// the result register once the output register is free. The table's single read
// port sets the one-step-per-cycle pace. in_stall_o stays high for the whole
// search; a finished result waits in the output register and the next word
// is accepted while it waits. An empty search (used_count zero) answers
// found 0, position 0 without a table read. Keys in entries never written read
// as undefined.
module sorted_table_binary_search (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bsrch_pkg::in_word_t                 in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bsrch_pkg::out_word_t                out_word_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bsrch_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bsrch_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned TABLE_DEPTH = bsrch_pkg::TABLE_DEPTH;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic [bsrch_pkg::POS_W-1:0] used_count_q;
  logic                        desc_q;
  logic [bsrch_pkg::POS_W-1:0] lo_q, lo_d;
  logic [bsrch_pkg::POS_W-1:0] n_q, n_d;
  logic [bsrch_pkg::KEY_W-1:0] key_q, key_d;
  logic                        hit_q, hit_d;
  logic [bsrch_pkg::POS_W-1:0] pos_q, pos_d;
  logic                        out_valid_q, out_valid_d;
  bsrch_pkg::out_word_t        out_word_q, out_word_d;

  logic [bsrch_pkg::POS_W-1:0] n_eff;
  logic                        in_acc;
  logic                        out_free;
  logic                        tbl_we;
  logic                        tbl_re;
  logic [AW-1:0]               tbl_raddr;
  logic [bsrch_pkg::KEY_W-1:0] tbl_rdata;
  bsrch_pkg::step_t            step;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_count_q <= '0;
      desc_q       <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bsrch_pkg::CFG_USED_COUNT: used_count_q <= cfg_data_i[bsrch_pkg::POS_W-1:0];
        bsrch_pkg::CFG_DESCENDING: desc_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // count saturates at the table depth
  assign n_eff = (32'(used_count_q) > TABLE_DEPTH) ? bsrch_pkg::POS_W'(TABLE_DEPTH)
                                                   : used_count_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign tbl_we = in_acc && (in_word_i.op == bsrch_pkg::OP_WRITE) &&
                  (32'(in_word_i.write_index) < TABLE_DEPTH);

  bsrch_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AW'(in_word_i.write_index)),
    .wdata_i (in_word_i.entry_value),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  bsrch_step u_step (
    .lo_i    (lo_q),
    .n_i     (n_q),
    .key_i   (key_q),
    .entry_i (tbl_rdata),
    .desc_i  (desc_q),
    .step_o  (step)
  );

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    n_d         = n_q;
    key_d       = key_q;
    hit_d       = hit_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    tbl_re      = 1'b0;
    tbl_raddr   = AW'(n_eff >> 1);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (in_word_i.op == bsrch_pkg::OP_SEARCH)) begin
          lo_d  = '0;
          n_d   = n_eff;
          key_d = in_word_i.search_key;
          if (n_eff == '0) begin
            hit_d   = 1'b0;
            pos_d   = '0;
            state_d = S_FINISH;
          end else begin
            tbl_re  = 1'b1;
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        lo_d      = step.next_lo;
        n_d       = step.next_n;
        tbl_raddr = AW'(step.next_probe);
        if (step.done) begin
          hit_d   = step.hit;
          pos_d   = step.pos;
          state_d = S_FINISH;
        end else begin
          tbl_re = 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_word_d.found    = hit_q;
          out_word_d.position = pos_q;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    n_q        <= n_d;
    key_q      <= key_d;
    hit_q      <= hit_d;
    pos_q      <= pos_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // the live range is never empty while a step is in flight
  a_range_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (n_q != '0))
    else $error("search step with empty range");

  // a new result only comes out of the finish state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FINISH))
    else $error("result raised outside finish");

  // insertion point never beyond the active count
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.position <= n_eff))
    else $error("position beyond active count");

  // a hit always names an active entry
  a_hit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.found) |-> (out_word_o.position < n_eff))
    else $error("hit position outside active entries");

endmodule
